>>> hw/rtl/obb_sat_pkg.sv
// ----------------------------------------------------------------------------
// obb_sat_pkg
// Shared constants and types for the oriented-box separating axis test.
// ----------------------------------------------------------------------------
`default_nettype none

package obb_sat_pkg;

  // Default coordinate width (signed Q12.4)
  localparam int COORD_WIDTH_DEFAULT = 16;

  // Control word from the sequencer to each axis lane
  typedef struct packed {
    logic load_axis;  // build the edge normal from the corners at both ends of the edge
    logic issue;      // project the presented corner pair this cycle
    logic first;      // first corner pair of a test: restart min/max
  } lane_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/obb_sat_corner_store.sv
// ----------------------------------------------------------------------------
// obb_sat_corner_store
// Corner registers for box A and box B. Written one corner pair per request;
// during a test both boxes rotate by one entry per step, so entry 0 of each
// box presents every corner in turn and four steps restore the order.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_sat_corner_store #(
  parameter int COORD_WIDTH = obb_sat_pkg::COORD_WIDTH_DEFAULT
) (
  input  wire                           clk,
  input  wire                           wr_en,
  input  wire        [1:0]              wr_slot,
  input  wire signed [COORD_WIDTH-1:0]  wr_a_x,
  input  wire signed [COORD_WIDTH-1:0]  wr_a_y,
  input  wire signed [COORD_WIDTH-1:0]  wr_b_x,
  input  wire signed [COORD_WIDTH-1:0]  wr_b_y,
  input  wire                           rotate,
  output logic signed [COORD_WIDTH-1:0] a0_x,
  output logic signed [COORD_WIDTH-1:0] a0_y,
  output logic signed [COORD_WIDTH-1:0] a1_x,
  output logic signed [COORD_WIDTH-1:0] a1_y,
  output logic signed [COORD_WIDTH-1:0] a3_x,
  output logic signed [COORD_WIDTH-1:0] a3_y,
  output logic signed [COORD_WIDTH-1:0] b0_x,
  output logic signed [COORD_WIDTH-1:0] b0_y,
  output logic signed [COORD_WIDTH-1:0] b1_x,
  output logic signed [COORD_WIDTH-1:0] b1_y,
  output logic signed [COORD_WIDTH-1:0] b3_x,
  output logic signed [COORD_WIDTH-1:0] b3_y
);

  logic signed [COORD_WIDTH-1:0] ax [4];
  logic signed [COORD_WIDTH-1:0] ay [4];
  logic signed [COORD_WIDTH-1:0] bx [4];
  logic signed [COORD_WIDTH-1:0] by [4];

  // Write the requested slot, or rotate both boxes by one corner
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ax[wr_slot] <= wr_a_x;
      ay[wr_slot] <= wr_a_y;
      bx[wr_slot] <= wr_b_x;
      by[wr_slot] <= wr_b_y;
    end else if (rotate) begin
      for (int i = 0; i < 4; i++) begin
        ax[2'(i)] <= ax[2'(i + 1)];
        ay[2'(i)] <= ay[2'(i + 1)];
        bx[2'(i)] <= bx[2'(i + 1)];
        by[2'(i)] <= by[2'(i + 1)];
      end
    end
  end

  // Fixed taps for edge normals and projection
  assign a0_x = ax[0];
  assign a0_y = ay[0];
  assign a1_x = ax[1];
  assign a1_y = ay[1];
  assign a3_x = ax[3];
  assign a3_y = ay[3];
  assign b0_x = bx[0];
  assign b0_y = by[0];
  assign b1_x = bx[1];
  assign b1_y = by[1];
  assign b3_x = bx[3];
  assign b3_y = by[3];

endmodule

`default_nettype wire

>>> hw/rtl/obb_sat_lane.sv
// ----------------------------------------------------------------------------
// obb_sat_lane
// One candidate axis: builds the edge normal, projects one corner of each box
// per step through a two-stage multiply/add pipe and tracks the projected
// interval of both boxes. Flags separation when the intervals have a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_sat_lane #(
  parameter int COORD_WIDTH = obb_sat_pkg::COORD_WIDTH_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst,
  input  obb_sat_pkg::lane_ctrl_t      ctrl,
  input  wire signed [COORD_WIDTH-1:0] p0_x,
  input  wire signed [COORD_WIDTH-1:0] p0_y,
  input  wire signed [COORD_WIDTH-1:0] p1_x,
  input  wire signed [COORD_WIDTH-1:0] p1_y,
  input  wire signed [COORD_WIDTH-1:0] ca_x,
  input  wire signed [COORD_WIDTH-1:0] ca_y,
  input  wire signed [COORD_WIDTH-1:0] cb_x,
  input  wire signed [COORD_WIDTH-1:0] cb_y,
  output logic                         sep
);

  localparam int NW = COORD_WIDTH + 1;     // edge / normal component
  localparam int PW = 2 * COORD_WIDTH + 1; // one product
  localparam int SW = 2 * COORD_WIDTH + 2; // dot product

  logic signed [NW-1:0] ex;
  logic signed [NW-1:0] ey;
  logic signed [NW-1:0] nx;
  logic signed [NW-1:0] ny;
  logic signed [PW-1:0] pax;
  logic signed [PW-1:0] pay;
  logic signed [PW-1:0] pbx;
  logic signed [PW-1:0] pby;
  logic signed [SW-1:0] proj_a;
  logic signed [SW-1:0] proj_b;
  logic signed [SW-1:0] amin;
  logic signed [SW-1:0] amax;
  logic signed [SW-1:0] bmin;
  logic signed [SW-1:0] bmax;
  logic                 v1;
  logic                 f1;
  logic                 v2;
  logic                 f2;

  // Edge vector from corner 0 to the neighbor corner
  assign ex = NW'(p1_x) - NW'(p0_x);
  assign ey = NW'(p1_y) - NW'(p0_y);

  // Latch the perpendicular; a zero-length edge falls back to the x axis
  always_ff @(posedge clk) begin
    if (ctrl.load_axis) begin
      if (ex == '0 && ey == '0) begin
        nx <= NW'(1);
        ny <= '0;
      end else begin
        nx <= -ey;
        ny <= ex;
      end
    end
  end

  // Pipe control: product stage, then sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      f1 <= 1'b0;
      v2 <= 1'b0;
      f2 <= 1'b0;
    end else begin
      v1 <= ctrl.issue;
      f1 <= ctrl.first;
      v2 <= v1;
      f2 <= f1;
    end
  end

  // Multiply corner coordinates by the normal
  always_ff @(posedge clk) begin
    pax <= PW'(ca_x) * PW'(nx);
    pay <= PW'(ca_y) * PW'(ny);
    pbx <= PW'(cb_x) * PW'(nx);
    pby <= PW'(cb_y) * PW'(ny);
  end

  // Add the partial products
  always_ff @(posedge clk) begin
    proj_a <= SW'(pax) + SW'(pay);
    proj_b <= SW'(pbx) + SW'(pby);
  end

  // Track the projected interval of each box
  always_ff @(posedge clk) begin
    if (v2) begin
      if (f2) begin
        amin <= proj_a;
        amax <= proj_a;
        bmin <= proj_b;
        bmax <= proj_b;
      end else begin
        if (proj_a < amin) amin <= proj_a;
        if (proj_a > amax) amax <= proj_a;
        if (proj_b < bmin) bmin <= proj_b;
        if (proj_b > bmax) bmax <= proj_b;
      end
    end
  end

  // Separated only on a strict gap
  assign sep = (amax < bmin) || (bmax < amin);

endmodule

`default_nettype wire

>>> hw/rtl/obb_separating_axis_test.sv
// ----------------------------------------------------------------------------
// obb_separating_axis_test
// Overlap test of two oriented rectangles by the separating axis theorem.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with one corner of box A and one of box B; the request is
//   taken at a clock edge where start is high and busy is low. Send corners
//   in perimeter order, 0 to 3, and mark the last pair with final_corner.
//   A request without final_corner is stored and busy stays low,
//   so corner requests may follow back to back.
//   A final_corner request runs the test: four axis lanes (two side normals
//   per box) each project one corner of both boxes per step, through a
//   multiply stage, an add stage and a min/max stage. The lanes'
//   separation flags are merged and overlap is registered together with done.
//   The sequencer steps through its normal, projection, drain and merge states;
//   busy is high from the final request until done is raised, so no request
//   is taken while a test runs.
//   The receiver cannot hold off results; done is a one-cycle strobe.
//   Reset (rst, synchronous) returns the corner counter to slot 0 and the
//   sequencer to idle; stored corners are kept until rewritten.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_separating_axis_test #(
  parameter int COORD_WIDTH = obb_sat_pkg::COORD_WIDTH_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire signed [COORD_WIDTH-1:0] a_corner_x,
  input  wire signed [COORD_WIDTH-1:0] a_corner_y,
  input  wire signed [COORD_WIDTH-1:0] b_corner_x,
  input  wire signed [COORD_WIDTH-1:0] b_corner_y,
  input  wire                          final_corner,
  output logic                         done,
  output logic                         overlap
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NORM  = 3'd1;
  localparam logic [2:0] ST_PROJ  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_MERGE = 3'd4;

  logic [2:0]                    state;
  logic [2:0]                    state_next;
  logic [1:0]                    corner_count;
  logic [1:0]                    step;
  logic [1:0]                    step_next;
  logic                          drain;
  logic                          accept;
  obb_sat_pkg::lane_ctrl_t       ctrl;
  logic [3:0]                    sep;
  logic signed [COORD_WIDTH-1:0] a0_x, a0_y, a1_x, a1_y, a3_x, a3_y;
  logic signed [COORD_WIDTH-1:0] b0_x, b0_y, b1_x, b1_y, b3_x, b3_y;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Corner storage
  obb_sat_corner_store #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_slot (corner_count),
    .wr_a_x  (a_corner_x),
    .wr_a_y  (a_corner_y),
    .wr_b_x  (b_corner_x),
    .wr_b_y  (b_corner_y),
    .rotate  (ctrl.issue),
    .a0_x    (a0_x),
    .a0_y    (a0_y),
    .a1_x    (a1_x),
    .a1_y    (a1_y),
    .a3_x    (a3_x),
    .a3_y    (a3_y),
    .b0_x    (b0_x),
    .b0_y    (b0_y),
    .b1_x    (b1_x),
    .b1_y    (b1_y),
    .b3_x    (b3_x),
    .b3_y    (b3_y)
  );

  // Axis lanes: A edge 0-1, A edge 0-3, B edge 0-1, B edge 0-3
  obb_sat_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane0 (
    .clk(clk), .rst(rst), .ctrl(ctrl),
    .p0_x(a0_x), .p0_y(a0_y), .p1_x(a1_x), .p1_y(a1_y),
    .ca_x(a0_x), .ca_y(a0_y), .cb_x(b0_x), .cb_y(b0_y),
    .sep(sep[0])
  );

  obb_sat_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane1 (
    .clk(clk), .rst(rst), .ctrl(ctrl),
    .p0_x(a0_x), .p0_y(a0_y), .p1_x(a3_x), .p1_y(a3_y),
    .ca_x(a0_x), .ca_y(a0_y), .cb_x(b0_x), .cb_y(b0_y),
    .sep(sep[1])
  );

  obb_sat_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane2 (
    .clk(clk), .rst(rst), .ctrl(ctrl),
    .p0_x(b0_x), .p0_y(b0_y), .p1_x(b1_x), .p1_y(b1_y),
    .ca_x(a0_x), .ca_y(a0_y), .cb_x(b0_x), .cb_y(b0_y),
    .sep(sep[2])
  );

  obb_sat_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane3 (
    .clk(clk), .rst(rst), .ctrl(ctrl),
    .p0_x(b0_x), .p0_y(b0_y), .p1_x(b3_x), .p1_y(b3_y),
    .ca_x(a0_x), .ca_y(a0_y), .cb_x(b0_x), .cb_y(b0_y),
    .sep(sep[3])
  );

  // Sequencer next state and lane control
  always_comb begin
    state_next     = state;
    step_next      = step;
    ctrl.load_axis = 1'b0;
    ctrl.issue     = 1'b0;
    ctrl.first     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && final_corner) state_next = ST_NORM;
      end
      ST_NORM: begin
        ctrl.load_axis = 1'b1;
        step_next      = '0;
        state_next     = ST_PROJ;
      end
      ST_PROJ: begin
        ctrl.issue = 1'b1;
        ctrl.first = (step == '0);
        step_next  = step + 2'd1;
        if (step == 2'd3) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain) state_next = ST_MERGE;
      end
      ST_MERGE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state, corner slot and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      corner_count <= '0;
      step         <= '0;
      drain        <= 1'b0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      drain <= (state == ST_DRAIN) ? !drain : 1'b0;
      done  <= (state == ST_MERGE);
      if (accept) begin
        corner_count <= final_corner ? 2'd0 : corner_count + 2'd1;
      end
    end
  end

  // Merge lane results: overlap unless some axis separates
  always_ff @(posedge clk) begin
    if (state == ST_MERGE) begin
      overlap <= ~(|sep);
    end
  end

endmodule

`default_nettype wire

>>> tb/obb_separating_axis_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_separating_axis_test_tb
// Self-checking bench for the oriented-box separating axis overlap test.
// ----------------------------------------------------------------------------
// Corner requests go in on the start/busy handshake. A scoreboard keeps its
// own copy of the eight stored corners and, on each final corner request,
// works out the overlap flag with exact 64-bit projections on the four side
// normals. Each done strobe is checked against the oldest pending flag.
// A short directed set comes first: identical boxes, full-scale coordinates,
// touching boxes, a diagonal separation, an early final mark, a point-sized
// box and a wrap past four corners. Random box pairs follow, mostly
// well-formed, with random corners, early finals and overlong runs mixed in.
// ----------------------------------------------------------------------------

module obb_separating_axis_test_tb;

  localparam int CW = obb_sat_pkg::COORD_WIDTH_DEFAULT;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int TARGET_REQUESTS = 550;
  localparam int QUIET_TAIL = 470;

  logic          clk = 1'b0;
  logic          rst;
  logic          start;
  logic          busy;
  logic [CW-1:0] a_corner_x;
  logic [CW-1:0] a_corner_y;
  logic [CW-1:0] b_corner_x;
  logic [CW-1:0] b_corner_y;
  logic          final_corner;
  logic          done;
  logic          overlap;

  // Mirror of the corner store and the overlap flags still owed by the block
  class overlap_scoreboard;
    bit signed [CW-1:0] a_x[4], a_y[4], b_x[4], b_y[4];
    bit [1:0]           next_slot;
    bit                 expected_overlap[$];
    int                 errors;

    // True when the projections of the two boxes on (nx, ny) leave a strict gap
    function bit separates_on(longint nx, longint ny);
      longint pa, pb, a_lo, a_hi, b_lo, b_hi;
      for (int i = 0; i < 4; i++) begin
        pa = a_x[i] * nx + a_y[i] * ny;
        pb = b_x[i] * nx + b_y[i] * ny;
        if (i == 0 || pa < a_lo) a_lo = pa;
        if (i == 0 || pa > a_hi) a_hi = pa;
        if (i == 0 || pb < b_lo) b_lo = pb;
        if (i == 0 || pb > b_hi) b_hi = pb;
      end
      return (a_hi < b_lo) || (b_hi < a_lo);
    endfunction

    // Test on the normal of one edge; a zero-length edge falls back to x
    function bit split_by_edge(longint x0, longint y0, longint x1, longint y1);
      longint ex, ey;
      ex = x1 - x0;
      ey = y1 - y0;
      if (ex == 0 && ey == 0) return separates_on(1, 0);
      return separates_on(-ey, ex);
    endfunction

    function bit predict_overlap();
      return !(split_by_edge(a_x[0], a_y[0], a_x[1], a_y[1]) ||
               split_by_edge(a_x[0], a_y[0], a_x[3], a_y[3]) ||
               split_by_edge(b_x[0], b_y[0], b_x[1], b_y[1]) ||
               split_by_edge(b_x[0], b_y[0], b_x[3], b_y[3]));
    endfunction

    // Store the corner pair; a final mark queues a flag and rewinds the slot
    function void note_request(bit signed [CW-1:0] ax, bit signed [CW-1:0] ay,
                               bit signed [CW-1:0] bx, bit signed [CW-1:0] by,
                               bit fin);
      a_x[next_slot] = ax;
      a_y[next_slot] = ay;
      b_x[next_slot] = bx;
      b_y[next_slot] = by;
      if (fin) begin
        expected_overlap = {expected_overlap, predict_overlap()};
        next_slot = 2'd0;
      end else begin
        next_slot = next_slot + 2'd1;
      end
    endfunction

    function void check_result(logic got);
      bit want;
      if (expected_overlap.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got overlap=%b", $time, got);
        return;
      end
      want = expected_overlap.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: overlap mismatch, expected %b, got %b", $time, want, got);
      end
    endfunction
  endclass

  overlap_scoreboard board;

  bit signed [CW-1:0] pair_ax[4], pair_ay[4], pair_bx[4], pair_by[4];
  int                 requests_sent;
  int                 gap_pct;
  int                 idle_cycles;

  obb_separating_axis_test #(
    .COORD_WIDTH (CW)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .a_corner_x   (a_corner_x),
    .a_corner_y   (a_corner_y),
    .b_corner_x   (b_corner_x),
    .b_corner_y   (b_corner_y),
    .final_corner (final_corner),
    .done         (done),
    .overlap      (overlap)
  );

  always #4 clk = ~clk;

  // Track accepted requests and check each result strobe
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        board.note_request(a_corner_x, a_corner_y, b_corner_x, b_corner_y, final_corner);
      end
      if (done) begin
        board.check_result(overlap);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int rnd_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Drop start for the requested gap, with noise on the corner inputs
  task automatic hold_off(input int n);
    start        <= 1'b0;
    a_corner_x   <= CW'($urandom);
    a_corner_y   <= CW'($urandom);
    b_corner_x   <= CW'($urandom);
    b_corner_y   <= CW'($urandom);
    final_corner <= 1'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Present one corner request and hold it until the block takes it
  task automatic issue(input bit signed [CW-1:0] ax, input bit signed [CW-1:0] ay,
                       input bit signed [CW-1:0] bx, input bit signed [CW-1:0] by,
                       input bit fin);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) hold_off($urandom_range(1, 15));
    start        <= 1'b1;
    a_corner_x   <= ax;
    a_corner_y   <= ay;
    b_corner_x   <= bx;
    b_corner_y   <= by;
    final_corner <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
  endtask

  // Send n corners of the current pair in perimeter order, final mark on the last
  task automatic send_pair(input int n);
    for (int i = 0; i < n; i++) begin
      issue(pair_ax[i % 4], pair_ay[i % 4], pair_bx[i % 4], pair_by[i % 4], i == n - 1);
    end
  endtask

  task automatic set_corner(input int i, input int ax, input int ay, input int bx,
                            input int by);
    pair_ax[i] = CW'(ax);
    pair_ay[i] = CW'(ay);
    pair_bx[i] = CW'(bx);
    pair_by[i] = CW'(by);
  endtask

  // Lay out a roughly rectangular box from origin (ox, oy); wraps at 16 bits
  task automatic place_box(input bit is_b, input int ox, input int oy, input int span);
    int e1x, e1y, e2x, e2y, m;
    int cx[4], cy[4];
    e1x = rnd_signed(span);
    e1y = rnd_signed(span);
    m   = $urandom_range(1, 4);
    e2x = -e1y * m / 2;
    e2y = e1x * m / 2;
    if ($urandom_range(0, 1)) begin
      e2x = -e2x;
      e2y = -e2y;
    end
    // Now and then collapse an edge to zero length
    case ($urandom_range(0, 7))
      0: begin
        e1x = 0;
        e1y = 0;
      end
      1: begin
        e2x = 0;
        e2y = 0;
      end
      default: ;
    endcase
    cx[0] = ox;       cy[0] = oy;
    cx[1] = ox + e1x; cy[1] = oy + e1y;
    cx[2] = cx[1] + e2x; cy[2] = cy[1] + e2y;
    cx[3] = ox + e2x; cy[3] = oy + e2y;
    for (int i = 0; i < 4; i++) begin
      if (is_b) begin
        pair_bx[i] = CW'(cx[i]);
        pair_by[i] = CW'(cy[i]);
      end else begin
        pair_ax[i] = CW'(cx[i]);
        pair_ay[i] = CW'(cy[i]);
      end
    end
  endtask

  // Two boxes close enough that overlap and separation both come up often
  task automatic build_pair();
    int span, ox, oy;
    span = ($urandom_range(0, 3) == 0) ? 8000 : 200;
    ox   = rnd_signed(2 * span);
    oy   = rnd_signed(2 * span);
    place_box(1'b0, ox, oy, span);
    place_box(1'b1, ox + rnd_signed(2 * span), oy + rnd_signed(2 * span), span);
  endtask

  initial begin
    int kind;
    board         = new;
    requests_sent = 0;
    gap_pct       = 0;
    rst          <= 1'b1;
    start        <= 1'b0;
    a_corner_x   <= '0;
    a_corner_y   <= '0;
    b_corner_x   <= '0;
    b_corner_y   <= '0;
    final_corner <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Identical squares; also fills every corner slot
    set_corner(0, 0, 0, 0, 0);
    set_corner(1, 160, 0, 160, 0);
    set_corner(2, 160, 160, 160, 160);
    set_corner(3, 0, 160, 0, 160);
    send_pair(4);

    // Full-scale box against a point box sitting on its far corner
    set_corner(0, -32768, -32768, 32767, 32767);
    set_corner(1, 32767, -32768, 32767, 32767);
    set_corner(2, 32767, 32767, 32767, 32767);
    set_corner(3, -32768, 32767, 32767, 32767);
    send_pair(4);

    // Boxes sharing an edge count as overlapping
    set_corner(0, 0, 0, 160, 0);
    set_corner(1, 160, 0, 320, 0);
    set_corner(2, 160, 160, 320, 160);
    set_corner(3, 0, 160, 160, 160);
    send_pair(4);

    // Diamond whose bounding box overlaps, split only on a diagonal axis
    set_corner(0, 0, 0, 230, 130);
    set_corner(1, 160, 0, 330, 230);
    set_corner(2, 160, 160, 230, 330);
    set_corner(3, 0, 160, 130, 230);
    send_pair(4);

    // Final mark on the very first corner
    issue(-16, -16, 5000, 5000, 1'b1);

    // Point-sized box A inside B, with the count wrapping past four corners
    set_corner(0, 80, 80, 0, 0);
    set_corner(1, 80, 80, 160, 0);
    set_corner(2, 80, 80, 160, 160);
    set_corner(3, 80, 80, 0, 160);
    send_pair(7);

    gap_pct = 20;
    while (requests_sent < TARGET_REQUESTS) begin
      if (requests_sent >= QUIET_TAIL) begin
        gap_pct = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 20;
          default: gap_pct = 60;
        endcase
      end
      kind = $urandom_range(0, 9);
      if (kind == 7) begin
        for (int i = 0; i < 4; i++) begin
          set_corner(i, $urandom, $urandom, $urandom, $urandom);
        end
      end else begin
        build_pair();
      end
      if (kind == 8) send_pair($urandom_range(1, 3));
      else if (kind == 9) send_pair($urandom_range(5, 8));
      else send_pair(4);
    end
    start <= 1'b0;

    // Drain outstanding results, then give the pipeline time to misbehave
    while (board.expected_overlap.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.expected_overlap.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
